[design/assert_macros.svh]
// assertion helpers shared by the checker modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define NSC_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("nsc assertion failed");
// expression must never be true outside reset
`define NSC_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("nsc forbidden condition seen");
`else
`define NSC_ASSERT(lbl, clk, rst, prop)
`define NSC_ASSERT_NEVER(lbl, clk, rst, expr)
`endif
`endif

[design/nsc_pkg.sv]
`default_nettype none
package nsc_pkg;

   // line length bookkeeping
   localparam int LINE_CAP = 128;
   localparam int POS_W = 7;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam int LIMIT_CAP_INT = (LINE_CAP - 1 < 127) ? LINE_CAP - 1 : 127;
   localparam logic [POS_W-1:0] LIMIT_CAP = LIMIT_CAP_INT[POS_W-1:0];
   localparam logic [POS_W-1:0] MIN_LINE_POS = 7'd6;
   localparam logic [POS_W-1:0] MIN_STATUS_POS = 7'd5;
   localparam int DELAY = 5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // special bytes
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR = 8'h2a;
   localparam logic [7:0] CH_CR = 8'h0d;
   localparam logic [7:0] CH_LF = 8'h0a;
   localparam logic [7:0] CH_XON = 8'h11;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_F = 8'h46;
   localparam logic [3:0] HEX_TEN = 4'ha;

   // result kinds
   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_SENTENCE = 2'd1;
   localparam logic [1:0] KIND_XFER = 2'd2;

   // sentence status codes
   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FRAMING = 3'd1;
   localparam logic [2:0] ST_HEX = 3'd2;
   localparam logic [2:0] ST_CHECKSUM = 3'd3;
   localparam logic [2:0] ST_OVERLONG = 3'd4;

   // one classified input byte: an optional payload byte, then an optional end item
   typedef struct packed {
      logic pay_vld;
      logic [7:0] pay;
      logic end_vld;
      logic [1:0] end_kind;
      logic [2:0] status;
   } entry_type;

endpackage
`default_nettype wire

[design/nmea_sentence_checker_core.sv]
// channel   dir  handshake          payload
// req       in   req_tvalid/tready  tdata[7:0] rx_byte
// rsp       out  rsp_tvalid/tready  tdata[7:0] payload_byte, [10:8] sentence_status;
//                                   tuser[1:0] item_kind; tlast last_of_run
// csr       in   csr_wr_en          csr_wr_data[6:0] max_line_length
//
// one byte is accepted per cycle while the two-entry queue has room
// a byte yields zero, one or two items; the back end sends one item per cycle while rsp is ready,
// so a byte that ends a line with a pending payload byte sends the payload item and then the end item
// an accepted byte's items pass through the queue slot and then the output register on the way to rsp
// reset is synchronous: line state, queue pointers and the output valid flag are cleared
// stalls on rsp back up into the queue and then into req_tready
`default_nettype none
module nmea_sentence_checker_core (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [6:0] csr_wr_data,     // max_line_length
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [7:0] req_tdata,       // [7:0] rx_byte
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [15:0] rsp_tdata,          // [7:0] payload_byte, [10:8] sentence_status
   output logic [1:0] rsp_tuser,           // [1:0] item_kind
   output logic rsp_tlast                  // last_of_run
);
   import nsc_pkg::*;

   logic push, q_full, q_empty, pop;
   entry_type push_data, head;

   // byte classification and line state
   nsc_front u_front (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .push(push),
      .push_data(push_data),
      .q_full(q_full)
   );

   // entry queue
   nsc_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_data(push_data),
      .full(q_full),
      .pop(pop),
      .head(head),
      .empty(q_empty)
   );

   // item expansion and output register
   nsc_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .empty(q_empty),
      .pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

endmodule
`default_nettype wire

[design/nsc_front.sv]
`default_nettype none
`include "assert_macros.svh"
module nsc_front (
   input wire logic clock,
   input wire logic reset,
   input wire logic csr_wr_en,
   input wire logic [6:0] csr_wr_data,
   input wire logic req_tvalid,
   output logic req_tready,
   input wire logic [7:0] req_tdata,
   output logic push,
   output nsc_pkg::entry_type push_data,
   input wire logic q_full
);
   import nsc_pkg::*;

   logic [6:0] max_len_ff;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0] recent_ff [DELAY];
   logic [7:0] xor_ff, xor_in;
   logic dollar_ff, dollar_in;
   logic ovf_ff, ovf_in;

   logic accept;
   logic [7:0] b;
   logic xon_start, is_lf;
   logic [POS_W-1:0] limit;
   logic ovf_now, dollar_now, pay_vld;
   logic hi_ok, lo_ok;
   logic [3:0] hi_val, lo_val;
   logic [2:0] status;

   // hex digit decode, upper case only
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         r = {1'b1, 4'(c - CH_ZERO)};
      end else if (c >= CH_UP_A && c <= CH_UP_F) begin
         r = {1'b1, 4'(c - CH_UP_A) + HEX_TEN};
      end
      return r;
   endfunction

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;
   assign b = req_tdata;

   // length limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= 7'd127;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // classify the incoming byte
   always_comb begin
      xon_start = (pos_ff == '0) && (b == CH_XON);
      is_lf = !xon_start && (b == CH_LF);
      limit = (LIMIT_CAP < max_len_ff) ? LIMIT_CAP : max_len_ff;
      ovf_now = ovf_ff || (pos_ff >= limit);
      dollar_now = (pos_ff == '0) ? (b == CH_DOLLAR) : dollar_ff;
      pay_vld = !xon_start && !ovf_now && (pos_ff >= MIN_LINE_POS);
      xor_in = pay_vld ? (xor_ff ^ recent_ff[0]) : xor_ff;
      {hi_ok, hi_val} = hex_decode(recent_ff[2]);
      {lo_ok, lo_val} = hex_decode(recent_ff[3]);
   end

   // sentence status at line end
   always_comb begin
      if (ovf_now) begin
         status = ST_OVERLONG;
      end else if (pos_ff < MIN_STATUS_POS || !dollar_now || recent_ff[1] != CH_STAR
                   || recent_ff[4] != CH_CR) begin
         status = ST_FRAMING;
      end else if (!hi_ok || !lo_ok) begin
         status = ST_HEX;
      end else if ({hi_val, lo_val} != xor_in) begin
         status = ST_CHECKSUM;
      end else begin
         status = ST_OK;
      end
   end

   // queue entry
   always_comb begin
      push = accept && (xon_start || pay_vld || is_lf);
      push_data.pay_vld = pay_vld;
      push_data.pay = recent_ff[0];
      push_data.end_vld = xon_start || is_lf;
      push_data.end_kind = xon_start ? KIND_XFER : KIND_SENTENCE;
      push_data.status = is_lf ? status : ST_OK;
   end

   // next line state
   always_comb begin
      pos_in = pos_ff;
      dollar_in = dollar_ff;
      ovf_in = ovf_ff;
      if (!xon_start) begin
         if (is_lf) begin
            pos_in = '0;
            dollar_in = 1'b0;
            ovf_in = 1'b0;
         end else begin
            pos_in = (pos_ff < POS_MAX) ? pos_ff + 1'b1 : POS_MAX;
            dollar_in = dollar_now;
            ovf_in = ovf_now;
         end
      end
   end

   // line state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         xor_ff <= 8'd0;
         dollar_ff <= 1'b0;
         ovf_ff <= 1'b0;
      end else if (accept && !xon_start) begin
         pos_ff <= pos_in;
         xor_ff <= is_lf ? 8'd0 : xor_in;
         dollar_ff <= dollar_in;
         ovf_ff <= ovf_in;
      end
   end

   // five byte delay line, only read once filled within the line
   always_ff @(posedge clock) begin
      if (accept && !xon_start && !is_lf) begin
         for (int i = 0; i < DELAY - 1; i++) begin
            recent_ff[i] <= recent_ff[i+1];
         end
         recent_ff[DELAY-1] <= b;
      end
   end

   `NSC_ASSERT(a_pay_after_six, clock, reset, !(push && push_data.pay_vld) || (pos_ff >= MIN_LINE_POS))

endmodule
`default_nettype wire

[design/nsc_queue.sv]
`default_nettype none
`include "assert_macros.svh"
module nsc_queue (
   input wire logic clock,
   input wire logic reset,
   input wire logic push,
   input wire nsc_pkg::entry_type push_data,
   output logic full,
   input wire logic pop,
   output nsc_pkg::entry_type head,
   output logic empty
);
   import nsc_pkg::*;

   entry_type slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic do_push, do_pop;

   assign full = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && !empty;

   // pointer wrap helper
   function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
      return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   `NSC_ASSERT(a_count_bound, clock, reset, count_ff <= QCNT_W'(QUEUE_DEPTH))
   `NSC_ASSERT_NEVER(a_push_full, clock, reset, push && full)

endmodule
`default_nettype wire

[design/nsc_back.sv]
`default_nettype none
`include "assert_macros.svh"
module nsc_back (
   input wire logic clock,
   input wire logic reset,
   input wire nsc_pkg::entry_type head,
   input wire logic empty,
   output logic pop,
   output logic rsp_tvalid,
   input wire logic rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic [1:0] rsp_tuser,
   output logic rsp_tlast
);
   import nsc_pkg::*;

   logic valid_ff, valid_in;
   logic sent_ff, sent_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] status_ff, status_in;
   logic last_ff, last_in;
   logic out_free, load, emit_pay;

   assign out_free = !valid_ff || rsp_tready;
   assign load = !empty && out_free;
   assign emit_pay = head.pay_vld && !sent_ff;

   // pick the next item of the head entry
   always_comb begin
      if (emit_pay) begin
         kind_in = KIND_PAYLOAD;
         byte_in = head.pay;
         status_in = ST_OK;
         last_in = !head.end_vld;
      end else begin
         kind_in = head.end_kind;
         byte_in = 8'd0;
         status_in = head.status;
         last_in = 1'b1;
      end
      pop = load && last_in;
      sent_in = load ? (emit_pay && head.end_vld) : sent_ff;
      valid_in = load || (valid_ff && !rsp_tready);
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sent_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sent_ff <= sent_in;
      end
   end

   // output item register
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff <= kind_in;
         byte_ff <= byte_in;
         status_ff <= status_in;
         last_ff <= last_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {5'd0, status_ff, byte_ff};
   assign rsp_tuser = kind_ff;
   assign rsp_tlast = last_ff;

   `NSC_ASSERT(a_xfer_last, clock, reset, !(valid_ff && kind_ff == KIND_XFER) || last_ff)
   `NSC_ASSERT(a_pay_no_status, clock, reset, !(valid_ff && kind_ff == KIND_PAYLOAD) || status_ff == ST_OK)

endmodule
`default_nettype wire

[sim/tb_top.sv]
module tb_top;
   import nsc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 8;
   localparam int REPORT_MAX = 10;
   localparam int MAX_GAP = 20;
   localparam logic [7:0] CH_LOW_A = 8'h61;

   // one item on the result channel, as the block reports it
   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] pay;
      logic [2:0] status;
      logic last;
   } nmea_item_type;

   typedef enum int {
      LN_GOOD, LN_BAD_SUM, LN_LOWER_HEX, LN_BAD_HEX, LN_NO_DOLLAR,
      LN_NO_STAR, LN_NO_CR, LN_SHORT, LN_NOISE, LN_XON
   } line_kind_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [6:0] csr_wr_data;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;     // [7:0] rx_byte
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;    // [7:0] payload_byte, [10:8] sentence_status
   logic [1:0] rsp_tuser;     // [1:0] item_kind
   logic rsp_tlast;           // last_of_run

   // sentence tracker state, mirrors the line state of the block
   logic [6:0] max_len_q;
   logic [6:0] line_pos;
   logic [7:0] recent [0:DELAY-1];
   logic [7:0] pay_xor;
   logic saw_dollar;
   logic too_long;

   nmea_item_type decoded_q [$];

   int errors = 0;
   int byte_count = 0;
   int n_items = 0;
   int n_payload = 0;
   int n_sentence = 0;
   int n_xfer = 0;
   int status_seen [0:7];
   int cycles = 0;

   int sender_idle_pct = 0;
   int rsp_stall_pct = 0;
   logic hold_toggle = 1'b0;
   logic hold_seen = 1'b0;
   int hold_left = 0;

   nmea_sentence_checker_core DUT (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("run stopped at cycle limit, %0d items outstanding", decoded_q.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   // hex digit value, 16 when not an upper-case hex digit
   function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE)
         return {1'b0, c[3:0]};
      if (c >= CH_UP_A && c <= CH_UP_F)
         return 5'(c - CH_UP_A) + 5'(HEX_TEN);
      return 5'd16;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] nib);
      if (nib < HEX_TEN)
         return CH_ZERO + 8'(nib);
      return CH_UP_A + 8'(nib - HEX_TEN);
   endfunction

   // status reported at LF, p is the number of bytes before the LF
   function automatic logic [2:0] sentence_verdict(input logic [6:0] p);
      logic [4:0] hi;
      logic [4:0] lo;
      if (too_long)
         return ST_OVERLONG;
      if (p < MIN_STATUS_POS)
         return ST_FRAMING;
      if (!saw_dollar || recent[1] != CH_STAR || recent[4] != CH_CR)
         return ST_FRAMING;
      hi = hex_digit_value(recent[2]);
      lo = hex_digit_value(recent[3]);
      if (hi[4] || lo[4])
         return ST_HEX;
      if ({hi[3:0], lo[3:0]} != pay_xor)
         return ST_CHECKSUM;
      return ST_OK;
   endfunction

   task automatic clear_line();
      line_pos = '0;
      foreach (recent[i])
         recent[i] = '0;
      pay_xor = '0;
      saw_dollar = 1'b0;
      too_long = 1'b0;
   endtask

   // works out the items that one accepted byte causes
   task automatic decode_byte(input logic [7:0] b);
      nmea_item_type got [$];
      logic [6:0] p;
      logic [6:0] lim;
      p = line_pos;
      lim = (max_len_q < LIMIT_CAP) ? max_len_q : LIMIT_CAP;
      if (p == 0 && b == CH_XON) begin
         got.push_back('{kind: KIND_XFER, pay: 8'h00, status: ST_OK, last: 1'b0});
      end else begin
         if (p >= lim)
            too_long = 1'b1;
         if (p == 0)
            saw_dollar = (b == CH_DOLLAR);
         // oldest byte of the delay line is now known to be payload
         if (!too_long && p >= MIN_LINE_POS) begin
            got.push_back('{kind: KIND_PAYLOAD, pay: recent[0], status: ST_OK, last: 1'b0});
            pay_xor ^= recent[0];
         end
         if (b == CH_LF) begin
            got.push_back('{kind: KIND_SENTENCE, pay: 8'h00, status: sentence_verdict(p),
                            last: 1'b0});
            clear_line();
         end else begin
            for (int i = 0; i < DELAY - 1; i++)
               recent[i] = recent[i + 1];
            recent[DELAY - 1] = b;
            if (p != POS_MAX)
               line_pos = p + 7'd1;
         end
      end
      if (got.size() > 0)
         got[got.size() - 1].last = 1'b1;
      foreach (got[i])
         decoded_q.push_back(got[i]);
      byte_count++;
   endtask

   // result side: check each item against the tracker
   always @(posedge clock) begin
      nmea_item_type seen;
      nmea_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = '{kind: rsp_tuser, pay: rsp_tdata[7:0], status: rsp_tdata[10:8],
                  last: rsp_tlast};
         n_items++;
         if (seen.kind == KIND_PAYLOAD)
            n_payload++;
         else if (seen.kind == KIND_SENTENCE) begin
            n_sentence++;
            status_seen[seen.status]++;
         end else if (seen.kind == KIND_XFER)
            n_xfer++;
         if (decoded_q.size() == 0) begin
            errors++;
            if (errors <= REPORT_MAX)
               $display("item %0d: none expected, got kind %0d byte %02h st %0d last %0b",
                        n_items, seen.kind, seen.pay, seen.status, seen.last);
         end else begin
            want = decoded_q.pop_front();
            if (seen.kind != want.kind || seen.pay != want.pay ||
                seen.status != want.status || seen.last != want.last) begin
               errors++;
               if (errors <= REPORT_MAX) begin
                  $display("item %0d: want kind %0d byte %02h st %0d last %0b",
                           n_items, want.kind, want.pay, want.status, want.last);
                  $display("item %0d:  got kind %0d byte %02h st %0d last %0b",
                           n_items, seen.kind, seen.pay, seen.status, seen.last);
               end
            end
         end
      end
   end

   // receiver ready: long hold-off on request, random stalls otherwise
   always @(posedge clock) begin
      if (hold_seen != hold_toggle) begin
         hold_seen = hold_toggle;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = 0;
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct && gap < MAX_GAP)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      decode_byte(b);
   endtask

   // stop offering and let every pending item come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_len(input logic [6:0] v);
      wait_drained();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      max_len_q = v;
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      sender_idle_pct = send_pct;
      rsp_stall_pct = recv_pct;
   endtask

   // random byte that is neither LF nor the given byte
   function automatic logic [7:0] pick_byte_except(input logic [7:0] avoid);
      logic [7:0] c;
      do
         c = 8'($urandom_range(255));
      while (c == CH_LF || c == avoid);
      return c;
   endfunction

   // builds one line of the given kind and sends it; n sets the payload bytes of a sentence
   task automatic send_line(input line_kind_type kind, input int n);
      logic [7:0] body [$];
      logic [7:0] sum;
      logic [7:0] c;
      logic [4:0] hv;
      sum = '0;
      case (kind)
         LN_XON: begin
            body.push_back(CH_XON);
         end
         LN_SHORT: begin
            repeat ($urandom_range(4)) body.push_back(pick_byte_except(CH_LF));
            body.push_back(CH_LF);
         end
         LN_NOISE: begin
            repeat ($urandom_range(1, 30)) body.push_back(8'($urandom_range(255)));
            body.push_back(CH_LF);
         end
         default: begin
            body.push_back(CH_DOLLAR);
            repeat (n) begin
               c = pick_byte_except(CH_LF);
               sum ^= c;
               body.push_back(c);
            end
            body.push_back(CH_STAR);
            body.push_back(hex_char(sum[7:4]));
            body.push_back(hex_char(sum[3:0]));
            body.push_back(CH_CR);
            body.push_back(CH_LF);
            // damage one part of an otherwise well-formed sentence
            case (kind)
               LN_BAD_SUM: begin
                  sum ^= 8'($urandom_range(1, 255));
                  body[n + 2] = hex_char(sum[7:4]);
                  body[n + 3] = hex_char(sum[3:0]);
               end
               LN_LOWER_HEX: begin
                  body[n + 2 + $urandom_range(1)] = CH_LOW_A + 8'($urandom_range(5));
               end
               LN_BAD_HEX: begin
                  do begin
                     c = pick_byte_except(CH_LF);
                     hv = hex_digit_value(c);
                  end while (!hv[4]);
                  body[n + 2 + $urandom_range(1)] = c;
               end
               LN_NO_DOLLAR: body[0] = pick_byte_except(CH_DOLLAR);
               LN_NO_STAR: body[n + 1] = pick_byte_except(CH_STAR);
               LN_NO_CR: body[n + 4] = pick_byte_except(CH_CR);
               default: ;
            endcase
         end
      endcase
      foreach (body[i])
         send_byte(body[i]);
   endtask

   // well-formed sentences for under half, the rest broken lines, noise and transfer ends
   function automatic line_kind_type pick_kind();
      int r;
      r = $urandom_range(99);
      if (r < 45) return LN_GOOD;
      if (r < 52) return LN_BAD_SUM;
      if (r < 57) return LN_LOWER_HEX;
      if (r < 62) return LN_BAD_HEX;
      if (r < 67) return LN_NO_DOLLAR;
      if (r < 72) return LN_NO_STAR;
      if (r < 77) return LN_NO_CR;
      if (r < 84) return LN_SHORT;
      if (r < 92) return LN_NOISE;
      return LN_XON;
   endfunction

   task automatic run_lines(input int budget, input int max_n);
      int start;
      start = byte_count;
      while (byte_count - start < budget)
         send_line(pick_kind(), $urandom_range(max_n));
   endtask

   // fixed lines: transfer end, shortest good line, field extremes, lower-case hex
   task automatic test_directed();
      logic [7:0] seq [$];
      set_idle(0, 0);
      write_max_len(7'd127);
      seq = '{CH_XON,
              CH_DOLLAR, CH_STAR, CH_ZERO, CH_ZERO, CH_CR, CH_LF,
              CH_DOLLAR, 8'h00, 8'hff, CH_XON, CH_STAR, hex_char(4'he), hex_char(4'he),
              CH_CR, CH_LF,
              CH_DOLLAR, CH_STAR, CH_ZERO, CH_LOW_A, CH_CR, CH_LF,
              CH_DOLLAR, CH_LF};
      foreach (seq[i])
         send_byte(seq[i]);
   endtask

   task automatic test_clean_sentences();
      int start;
      set_idle(0, 0);
      start = byte_count;
      while (byte_count - start < 200)
         send_line(LN_GOOD, $urandom_range(24));
   endtask

   task automatic test_broken_sentences();
      set_idle(46, 0);
      run_lines(250, 24);
   endtask

   // line limits at and around the extremes, plus position saturation
   task automatic test_length_limits();
      set_idle(0, 46);
      write_max_len(7'd6);
      run_lines(60, 3);
      write_max_len(7'd0);
      run_lines(40, 3);
      write_max_len(7'd5);
      run_lines(40, 3);
      write_max_len(7'd20);
      run_lines(80, 18);
      write_max_len(7'($urandom_range(6, 40)));
      run_lines(60, 40);
      write_max_len(7'd127);
      send_line(LN_GOOD, 121);
      send_line(LN_GOOD, 122);
      send_line(LN_BAD_SUM, 135);
   endtask

   // result side held off while bytes keep coming, then a full drain
   task automatic test_backpressure();
      int start;
      set_idle(0, 0);
      hold_toggle = ~hold_toggle;
      start = byte_count;
      while (byte_count - start < 150)
         send_line(LN_GOOD, $urandom_range(10, 30));
      wait_drained();
      set_idle(0, 46);
      run_lines(40, 20);
   endtask

   task automatic test_random_mix();
      set_idle(8, 8);
      repeat (4) begin
         if ($urandom_range(3) == 0)
            write_max_len(7'($urandom_range(5)));
         else
            write_max_len(7'($urandom_range(6, 127)));
         run_lines(60, 30);
      end
   endtask

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      foreach (status_seen[i])
         status_seen[i] = 0;
      max_len_q = 7'd127;
      clear_line();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_clean_sentences();
      test_broken_sentences();
      test_length_limits();
      test_backpressure();
      test_random_mix();

      wait_drained();
      errors += decoded_q.size();
      $display("%0d bytes sent: %0d payload items, %0d sentence reports, %0d transfer ends",
               byte_count, n_payload, n_sentence, n_xfer);
      $display("sentence status: ok %0d framing %0d hex %0d checksum %0d overlong %0d",
               status_seen[ST_OK], status_seen[ST_FRAMING], status_seen[ST_HEX],
               status_seen[ST_CHECKSUM], status_seen[ST_OVERLONG]);
      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
